[rtl/pid_with_deadband_and_clamps_core_macros.svh]
// assertion macros shared by the pid core
`ifndef PID_WITH_DEADBAND_AND_CLAMPS_CORE_MACROS_SVH
`define PID_WITH_DEADBAND_AND_CLAMPS_CORE_MACROS_SVH

// checked property, switched off while reset is high
`define PID_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property, live through reset as well
`define PID_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/pid_dbc_pkg.sv]
// types and constants of the pid core
`timescale 1ns / 1ps

package pid_dbc_pkg;

   localparam int DATA_W      = 32;
   localparam int PERIOD_W    = 16;
   localparam int PERIOD_FRAC = 16;
   localparam int DEAD_W      = 31;
   localparam int CSR_IDX_W   = 3;
   localparam int LIMIT_UNITS = 1000;

   localparam int MUL_STEPS = DATA_W;
   localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);
   localparam int DIV_W     = DATA_W + PERIOD_FRAC;
   localparam int DIV_STEPS = DIV_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN_P,
      REG_GAIN_I,
      REG_GAIN_D,
      REG_DRIVE_MIN,
      REG_DRIVE_MAX,
      REG_ACCUM_MIN,
      REG_ACCUM_MAX,
      REG_DEAD_ZONE
   } csr_reg_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ERR,
      S_DEAD,
      S_LAUNCH,
      S_DLOAD,
      S_WAIT0,
      S_ACC,
      S_ACLAMP,
      S_KI,
      S_WAIT1,
      S_DSAT,
      S_KD,
      S_WAIT2,
      S_SUM1,
      S_SUM2,
      S_OUT
   } state_type;

   typedef struct packed {
      logic                     start;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
   } mul_cmd_type;

   typedef struct packed {
      logic                       busy;
      logic signed [2*DATA_W-1:0] product;
   } mul_stat_type;

endpackage

[rtl/pid_dbc_smul.sv]
// bit-serial signed 32 x 32 multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module pid_dbc_smul
   import pid_dbc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  mul_cmd_type  cmd,
   output mul_stat_type stat
);

   logic signed [DATA_W-1:0] a_ff, a_in;
   logic [DATA_W-1:0]        b_ff, b_in;
   logic [DATA_W-1:0]        lo_ff, lo_in;
   logic signed [DATA_W:0]   hi_ff, hi_in;
   logic [MUL_CNT_W-1:0]     cnt_ff, cnt_in;

   logic signed [DATA_W+1:0] a_ext;
   logic signed [DATA_W+1:0] addend;
   logic signed [DATA_W+1:0] psum;

   assign a_ext = {a_ff[DATA_W-1], a_ff[DATA_W-1], a_ff};

   // sign bit of the multiplier carries negative weight
   always_comb begin
      addend = '0;
      if (b_ff[0]) begin
         if (cnt_ff == MUL_CNT_W'(1)) begin
            addend = -a_ext;
         end else begin
            addend = a_ext;
         end
      end
   end

   assign psum = {hi_ff[DATA_W], hi_ff} + addend;

   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      hi_in  = hi_ff;
      lo_in  = lo_ff;
      cnt_in = cnt_ff;
      if (cmd.start) begin
         a_in   = cmd.a;
         b_in   = cmd.b;
         hi_in  = '0;
         cnt_in = MUL_CNT_W'(MUL_STEPS);
      end else if (cnt_ff != '0) begin
         hi_in  = psum[DATA_W+1:1];
         lo_in  = {psum[0], lo_ff[DATA_W-1:1]};
         b_in   = {1'b0, b_ff[DATA_W-1:1]};
         cnt_in = cnt_ff - MUL_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      b_ff  <= b_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign stat.busy    = (cnt_ff != '0);
   assign stat.product = {hi_ff[DATA_W-1:0], lo_ff};

endmodule

[rtl/pid_with_deadband_and_clamps_core.sv]
// top level of the positional pid core with deadband and clamps
`timescale 1ns / 1ps
`include "pid_with_deadband_and_clamps_core_macros.svh"

// Positional PID controller in signed fixed point (FRAC_BITS fraction bits,
// Q16.16 by default). An update beat runs from acceptance to its drive beat
// through these steps: the error and deadband are formed in their own states,
// then two bit-serial multipliers form error*period and Kp*error while a
// 48-step restoring divider works out the derivative (skipped when no
// derivative is formed); Ki*integral runs as soon as the integral is clamped,
// and Kd*derivative follows the divider, which makes the divide plus one
// multiply the critical path. A new beat is taken once the drive beat sits in
// the output register, even if it is still stalled. A reset beat clears the
// integral, the previous error and the first-update flag and gives no drive
// beat. Register writes are taken while the core is idle; a write to either
// integral limit re-clamps the stored integral.
module pid_with_deadband_and_clamps_core
   import pid_dbc_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_kind,
   input  logic signed [DATA_W-1:0] req_setpoint,
   input  logic signed [DATA_W-1:0] req_measured,
   input  logic [PERIOD_W-1:0]      req_period,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_drive,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_data
);

   localparam int TERM_W = 2*DATA_W - FRAC_BITS;
   localparam int SUM_W  = TERM_W + 2;

   localparam logic signed [63:0] LIM_RAW = 64'(LIMIT_UNITS) <<< FRAC_BITS;
   localparam logic signed [63:0] LIM_CAP = 64'sd2147483647;
   localparam logic signed [DATA_W-1:0] LIM_HI =
      (LIM_RAW > LIM_CAP) ? LIM_CAP[DATA_W-1:0] : LIM_RAW[DATA_W-1:0];
   localparam logic signed [DATA_W-1:0] LIM_LO = -LIM_HI;

   function automatic logic signed [DATA_W-1:0] clamp_word(
      input logic signed [DATA_W:0]   v,
      input logic signed [DATA_W-1:0] lo,
      input logic signed [DATA_W-1:0] hi
   );
      logic signed [DATA_W:0]   lo_x;
      logic signed [DATA_W:0]   hi_x;
      logic signed [DATA_W-1:0] r;
      lo_x = {lo[DATA_W-1], lo};
      hi_x = {hi[DATA_W-1], hi};
      if (v < lo_x) begin
         r = lo;
      end else if (v > hi_x) begin
         r = hi;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] clamp_sum(
      input logic signed [SUM_W-1:0]  v,
      input logic signed [DATA_W-1:0] lo,
      input logic signed [DATA_W-1:0] hi
   );
      logic signed [SUM_W-1:0]  lo_x;
      logic signed [SUM_W-1:0]  hi_x;
      logic signed [DATA_W-1:0] r;
      lo_x = {{(SUM_W-DATA_W){lo[DATA_W-1]}}, lo};
      hi_x = {{(SUM_W-DATA_W){hi[DATA_W-1]}}, hi};
      if (v < lo_x) begin
         r = lo;
      end else if (v > hi_x) begin
         r = hi;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   state_type state_ff, state_in;

   logic signed [DATA_W-1:0] gain_p_ff, gain_p_in;
   logic signed [DATA_W-1:0] gain_i_ff, gain_i_in;
   logic signed [DATA_W-1:0] gain_d_ff, gain_d_in;
   logic signed [DATA_W-1:0] drive_min_ff, drive_min_in;
   logic signed [DATA_W-1:0] drive_max_ff, drive_max_in;
   logic signed [DATA_W-1:0] accum_min_ff, accum_min_in;
   logic signed [DATA_W-1:0] accum_max_ff, accum_max_in;
   logic [DEAD_W-1:0]        dead_zone_ff, dead_zone_in;

   logic signed [DATA_W-1:0] accum_ff, accum_in;
   logic signed [DATA_W-1:0] last_err_ff, last_err_in;
   logic                     first_ff, first_in;

   logic signed [DATA_W-1:0] sp_ff, sp_in;
   logic signed [DATA_W-1:0] meas_ff, meas_in;
   logic [PERIOD_W-1:0]      dt_ff, dt_in;
   logic signed [DATA_W-1:0] err_ff, err_in;
   logic signed [DATA_W:0]   diff_ff, diff_in;
   logic                     use_d_ff, use_d_in;
   logic signed [DATA_W:0]   acc_sum_ff, acc_sum_in;
   logic signed [DATA_W-1:0] deriv_ff, deriv_in;
   logic signed [TERM_W-1:0] term_p_ff, term_p_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;

   logic [DIV_W-1:0]         div_q_ff, div_q_in;
   logic [PERIOD_W-1:0]      div_rem_ff, div_rem_in;
   logic                     div_neg_ff, div_neg_in;
   logic [DIV_CNT_W-1:0]     div_cnt_ff, div_cnt_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_drive_ff, rsp_drive_in;

   mul_cmd_type  mul0_cmd, mul1_cmd;
   mul_stat_type mul0_stat, mul1_stat;

   logic div_load;
   logic out_load;
   logic req_take;
   logic csr_take;

   logic signed [DATA_W:0]   err_diff;
   logic [DATA_W:0]          err_mag;
   logic [DATA_W:0]          diff_mag;
   logic [PERIOD_W:0]        div_trial;
   logic [PERIOD_W:0]        div_sub;
   logic                     div_ge;
   logic                     div_big_neg;
   logic                     div_big_pos;
   logic signed [DATA_W-1:0] deriv_sat;
   logic signed [DATA_W-1:0] inc;
   logic signed [TERM_W-1:0] term0;
   logic signed [TERM_W-1:0] term1;

   pid_dbc_smul u_mul0 (
      .clock (clock),
      .reset (reset),
      .cmd   (mul0_cmd),
      .stat  (mul0_stat)
   );

   pid_dbc_smul u_mul1 (
      .clock (clock),
      .reset (reset),
      .cmd   (mul1_cmd),
      .stat  (mul1_stat)
   );

   assign req_take = req_valid && !req_stall;
   assign csr_take = csr_valid && csr_ready;

   assign err_diff  = {sp_ff[DATA_W-1], sp_ff} - {meas_ff[DATA_W-1], meas_ff};
   assign err_mag   = err_ff[DATA_W-1] ? -{err_ff[DATA_W-1], err_ff}
                                       : {err_ff[DATA_W-1], err_ff};
   assign diff_mag  = diff_ff[DATA_W] ? -diff_ff : diff_ff;
   assign div_trial = {div_rem_ff, div_q_ff[DIV_W-1]};
   assign div_sub   = div_trial - {1'b0, dt_ff};
   assign div_ge    = (div_trial >= {1'b0, dt_ff});

   assign div_big_neg = (div_q_ff[DIV_W-1:DATA_W] != '0) ||
                        (div_q_ff[DATA_W-1] && (div_q_ff[DATA_W-2:0] != '0));
   assign div_big_pos = (div_q_ff[DIV_W-1:DATA_W-1] != '0);

   always_comb begin
      if (div_neg_ff) begin
         deriv_sat = div_big_neg ? DATA_MIN : -div_q_ff[DATA_W-1:0];
      end else begin
         deriv_sat = div_big_pos ? DATA_MAX : div_q_ff[DATA_W-1:0];
      end
   end

   assign inc   = mul0_stat.product[DATA_W+PERIOD_FRAC-1:PERIOD_FRAC];
   assign term0 = mul0_stat.product[2*DATA_W-1:FRAC_BITS];
   assign term1 = mul1_stat.product[2*DATA_W-1:FRAC_BITS];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_kind) begin
               state_in = S_ERR;
            end
         end
         S_ERR:    state_in = S_DEAD;
         S_DEAD:   state_in = S_LAUNCH;
         S_LAUNCH: state_in = S_DLOAD;
         S_DLOAD:  state_in = S_WAIT0;
         S_WAIT0: begin
            if (!mul0_stat.busy && !mul1_stat.busy) begin
               state_in = S_ACC;
            end
         end
         S_ACC:    state_in = S_ACLAMP;
         S_ACLAMP: state_in = S_KI;
         S_KI:     state_in = S_WAIT1;
         S_WAIT1: begin
            if (div_cnt_ff == '0) begin
               state_in = S_DSAT;
            end
         end
         S_DSAT:   state_in = S_KD;
         S_KD:     state_in = S_WAIT2;
         S_WAIT2: begin
            if (!mul0_stat.busy && !mul1_stat.busy) begin
               state_in = S_SUM1;
            end
         end
         S_SUM1:   state_in = S_SUM2;
         S_SUM2:   state_in = S_OUT;
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall     = 1'b1;
      csr_ready     = 1'b0;
      div_load      = 1'b0;
      out_load      = 1'b0;
      mul0_cmd      = '0;
      mul1_cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            csr_ready = 1'b1;
         end
         S_LAUNCH: begin
            mul0_cmd.start = 1'b1;
            mul0_cmd.a     = err_ff;
            mul0_cmd.b     = {{(DATA_W-PERIOD_W){1'b0}}, dt_ff};
            mul1_cmd.start = 1'b1;
            mul1_cmd.a     = gain_p_ff;
            mul1_cmd.b     = err_ff;
         end
         S_DLOAD: div_load = use_d_ff;
         S_KI: begin
            mul0_cmd.start = 1'b1;
            mul0_cmd.a     = gain_i_ff;
            mul0_cmd.b     = accum_ff;
         end
         S_KD: begin
            mul1_cmd.start = 1'b1;
            mul1_cmd.a     = gain_d_ff;
            mul1_cmd.b     = deriv_ff;
         end
         S_OUT: out_load = !rsp_valid_ff || !rsp_stall;
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      gain_p_in    = gain_p_ff;
      gain_i_in    = gain_i_ff;
      gain_d_in    = gain_d_ff;
      drive_min_in = drive_min_ff;
      drive_max_in = drive_max_ff;
      accum_min_in = accum_min_ff;
      accum_max_in = accum_max_ff;
      dead_zone_in = dead_zone_ff;
      accum_in     = accum_ff;
      last_err_in  = last_err_ff;
      first_in     = first_ff;
      sp_in        = sp_ff;
      meas_in      = meas_ff;
      dt_in        = dt_ff;
      err_in       = err_ff;
      diff_in      = diff_ff;
      use_d_in     = use_d_ff;
      acc_sum_in   = acc_sum_ff;
      deriv_in     = deriv_ff;
      term_p_in    = term_p_ff;
      sum_in       = sum_ff;
      div_q_in     = div_q_ff;
      div_rem_in   = div_rem_ff;
      div_neg_in   = div_neg_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_drive_in = rsp_drive_ff;

      if (csr_take) begin
         case (csr_reg_type'(csr_index))
            REG_GAIN_P:    gain_p_in    = csr_data;
            REG_GAIN_I:    gain_i_in    = csr_data;
            REG_GAIN_D:    gain_d_in    = csr_data;
            REG_DRIVE_MIN: drive_min_in = csr_data;
            REG_DRIVE_MAX: drive_max_in = csr_data;
            REG_ACCUM_MIN: begin
               accum_min_in = csr_data;
               accum_in     = clamp_word({accum_ff[DATA_W-1], accum_ff},
                                         csr_data, accum_max_ff);
            end
            REG_ACCUM_MAX: begin
               accum_max_in = csr_data;
               accum_in     = clamp_word({accum_ff[DATA_W-1], accum_ff},
                                         accum_min_ff, csr_data);
            end
            REG_DEAD_ZONE: dead_zone_in = csr_data[DEAD_W-1:0];
            default: ;
         endcase
      end

      if (req_take) begin
         sp_in   = req_setpoint;
         meas_in = req_measured;
         dt_in   = req_period;
         if (req_kind) begin
            accum_in    = '0;
            last_err_in = '0;
            first_in    = 1'b1;
         end
      end

      // restoring divide, one quotient bit a cycle
      if (div_cnt_ff != '0) begin
         div_rem_in = div_ge ? div_sub[PERIOD_W-1:0] : div_trial[PERIOD_W-1:0];
         div_q_in   = {div_q_ff[DIV_W-2:0], div_ge};
         div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
      end

      case (state_ff)
         S_ERR: begin
            if (err_diff[DATA_W] != err_diff[DATA_W-1]) begin
               err_in = err_diff[DATA_W] ? DATA_MIN : DATA_MAX;
            end else begin
               err_in = err_diff[DATA_W-1:0];
            end
         end
         S_DEAD: begin
            if (err_mag <= {2'b00, dead_zone_ff}) begin
               err_in = '0;
            end
         end
         S_LAUNCH: begin
            diff_in     = {err_ff[DATA_W-1], err_ff} - {last_err_ff[DATA_W-1], last_err_ff};
            use_d_in    = (dt_ff != '0) && !first_ff;
            last_err_in = err_ff;
            first_in    = 1'b0;
         end
         S_DLOAD: begin
            if (div_load) begin
               div_neg_in = diff_ff[DATA_W];
               div_q_in   = {diff_mag[DATA_W-1:0], {PERIOD_FRAC{1'b0}}};
               div_rem_in = '0;
               div_cnt_in = DIV_CNT_W'(DIV_STEPS);
            end
         end
         S_ACC: begin
            acc_sum_in = {accum_ff[DATA_W-1], accum_ff} + {inc[DATA_W-1], inc};
         end
         S_ACLAMP: begin
            if (dt_ff != '0) begin
               accum_in = clamp_word(acc_sum_ff, accum_min_ff, accum_max_ff);
            end
         end
         S_DSAT: begin
            deriv_in = use_d_ff ? deriv_sat : '0;
         end
         S_KD: begin
            term_p_in = term1;
         end
         S_SUM1: begin
            sum_in = {{2{term_p_ff[TERM_W-1]}}, term_p_ff} + {{2{term0[TERM_W-1]}}, term0};
         end
         S_SUM2: begin
            sum_in = sum_ff + {{2{term1[TERM_W-1]}}, term1};
         end
         default: ;
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_drive_in = clamp_sum(sum_ff, drive_min_ff, drive_max_ff);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         drive_min_ff <= LIM_LO;
         drive_max_ff <= LIM_HI;
         accum_min_ff <= LIM_LO;
         accum_max_ff <= LIM_HI;
         dead_zone_ff <= '0;
         accum_ff     <= '0;
         last_err_ff  <= '0;
         first_ff     <= 1'b1;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_p_ff    <= gain_p_in;
         gain_i_ff    <= gain_i_in;
         gain_d_ff    <= gain_d_in;
         drive_min_ff <= drive_min_in;
         drive_max_ff <= drive_max_in;
         accum_min_ff <= accum_min_in;
         accum_max_ff <= accum_max_in;
         dead_zone_ff <= dead_zone_in;
         accum_ff     <= accum_in;
         last_err_ff  <= last_err_in;
         first_ff     <= first_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sp_ff        <= sp_in;
      meas_ff      <= meas_in;
      dt_ff        <= dt_in;
      err_ff       <= err_in;
      diff_ff      <= diff_in;
      use_d_ff     <= use_d_in;
      acc_sum_ff   <= acc_sum_in;
      deriv_ff     <= deriv_in;
      term_p_ff    <= term_p_in;
      sum_ff       <= sum_in;
      div_q_ff     <= div_q_in;
      div_rem_ff   <= div_rem_in;
      div_neg_ff   <= div_neg_in;
      rsp_drive_ff <= rsp_drive_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

   `PID_ASSERT(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT), "drive beat loaded outside output state")
   `PID_ASSERT(a_mul0_free, clock, reset, mul0_cmd.start |-> !mul0_stat.busy, "multiplier restarted while busy")
   `PID_ASSERT(a_div_done, clock, reset, (state_ff == S_DSAT) |-> (div_cnt_ff == '0), "derivative taken before divide finished")
   `PID_ASSERT(a_accum_clamped, clock, reset, (state_ff == S_ACLAMP && dt_ff != '0 && accum_min_ff <= accum_max_ff) |=> (accum_ff >= accum_min_ff && accum_ff <= accum_max_ff), "integral outside its limits")
   `PID_ASSERT_NR(a_reset_quiet, clock, reset |=> (!rsp_valid_ff && state_ff == S_IDLE), "core not idle after reset")

endmodule
